FILE: rtl/amf0_object_stream_decoder_unit_defines.svh
// assertion macros used by the decoder top
`ifndef AMF0_OBJECT_STREAM_DECODER_UNIT_DEFINES_SVH
`define AMF0_OBJECT_STREAM_DECODER_UNIT_DEFINES_SVH

// same-cycle implication, disabled while reset is low
`define AMF0_ASSERT_IMPLY(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("amf0 decoder check failed");

// next-cycle implication, disabled while reset is low
`define AMF0_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("amf0 decoder check failed");

`endif

FILE: rtl/amf0osd_pkg.sv
package amf0osd_pkg;

    typedef enum logic [3:0] {
        PH_IDLE      = 4'd0,
        PH_COUNT     = 4'd1,
        PH_KLEN_HI   = 4'd2,
        PH_KLEN_LO   = 4'd3,
        PH_KEY       = 4'd4,
        PH_TYPE      = 4'd5,
        PH_NUM       = 4'd6,
        PH_BOOL      = 4'd7,
        PH_SLEN_HI   = 4'd8,
        PH_SLEN_LO   = 4'd9,
        PH_STR       = 4'd10,
        PH_KLEN_HI_S = 4'd11
    } t_phase;

    // event kinds
    localparam logic [2:0] EV_KEY_BYTE = 3'd0;
    localparam logic [2:0] EV_KEY_DONE = 3'd1;
    localparam logic [2:0] EV_NUMBER   = 3'd2;
    localparam logic [2:0] EV_BOOL     = 3'd3;
    localparam logic [2:0] EV_STR_BYTE = 3'd4;
    localparam logic [2:0] EV_STR_DONE = 3'd5;
    localparam logic [2:0] EV_END      = 3'd6;
    localparam logic [2:0] EV_ERROR    = 3'd7;

    // error codes
    localparam logic [1:0] ERR_NONE      = 2'd0;
    localparam logic [1:0] ERR_BAD_TOP   = 2'd1;
    localparam logic [1:0] ERR_BAD_TYPE  = 2'd2;
    localparam logic [1:0] ERR_TRUNCATED = 2'd3;

    // markers
    localparam logic [7:0] MK_OBJECT  = 8'h03;
    localparam logic [7:0] MK_ECMA    = 8'h08;
    localparam logic [7:0] MK_OBJ_END = 8'h09;
    localparam logic [7:0] TY_NUMBER  = 8'h00;
    localparam logic [7:0] TY_BOOL    = 8'h01;
    localparam logic [7:0] TY_STRING  = 8'h02;
    localparam logic [7:0] BOOL_TRUE  = 8'h01;

    localparam logic [15:0] ECMA_COUNT_BYTES = 16'd4;
    localparam logic [15:0] NUMBER_BYTES     = 16'd8;

    // operation handed from the parser to the result stage
    typedef struct packed {
        logic        emit;    // produces a result word
        logic        shift;   // number byte, shift only
        logic [2:0]  kind;
        logic [7:0]  data;
        logic [31:0] len;
        logic [1:0]  err;
        logic        fin;
    } t_op;

endpackage

FILE: rtl/amf0osd_front.sv
module amf0osd_front
    import amf0osd_pkg::*;
(
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  logic       i_acc,
    input  logic [7:0] i_data_byte,
    input  logic       i_first_byte,
    input  logic       i_buffer_end,
    output logic       o_op_valid,
    output t_op        o_op
);

    t_phase      r_phase, n_phase, w_step_phase;
    logic [15:0] r_fc, n_fc;
    logic [15:0] r_pl, n_pl;
    logic [31:0] r_ct, n_ct;
    logic [15:0] w_fc_dec;
    logic [15:0] w_len_lo;

    assign w_fc_dec = r_fc - 16'd1;
    assign w_len_lo = {r_pl[15:8], i_data_byte};

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase <= PH_IDLE;
            r_fc    <= '0;
            r_pl    <= '0;
            r_ct    <= '0;
        end else begin
            r_phase <= n_phase;
            r_fc    <= n_fc;
            r_pl    <= n_pl;
            r_ct    <= n_ct;
        end
    end

    // next state
    always_comb begin
        w_step_phase = r_phase;
        n_fc         = r_fc;
        n_pl         = r_pl;
        n_ct         = r_ct;
        if (i_acc) begin
            if (i_first_byte) begin
                n_fc = '0;
                n_pl = '0;
                n_ct = 32'd1;
                if (i_data_byte == MK_OBJECT) begin
                    w_step_phase = PH_KLEN_HI;
                end else if (i_data_byte == MK_ECMA) begin
                    w_step_phase = PH_COUNT;
                    n_fc         = ECMA_COUNT_BYTES;
                end else begin
                    w_step_phase = PH_IDLE;
                end
            end else if (r_phase != PH_IDLE) begin
                n_ct = (r_ct == 32'hFFFF_FFFF) ? r_ct : r_ct + 32'd1;
                case (r_phase)
                    PH_COUNT: begin
                        n_fc = w_fc_dec;
                        if (w_fc_dec == 16'd0) w_step_phase = PH_KLEN_HI;
                    end
                    PH_KLEN_HI, PH_KLEN_HI_S: begin
                        n_pl         = {i_data_byte, 8'h00};
                        w_step_phase = PH_KLEN_LO;
                    end
                    PH_KLEN_LO: begin
                        n_pl = w_len_lo;
                        if (w_len_lo != 16'd0) begin
                            n_fc         = w_len_lo;
                            w_step_phase = PH_KEY;
                        end else begin
                            w_step_phase = PH_TYPE;
                        end
                    end
                    PH_KEY: begin
                        n_fc = w_fc_dec;
                        if (w_fc_dec == 16'd0) w_step_phase = PH_TYPE;
                    end
                    PH_TYPE: begin
                        if (r_pl == 16'd0 && i_data_byte == MK_OBJ_END) begin
                            w_step_phase = PH_IDLE;
                        end else if (i_data_byte == TY_NUMBER) begin
                            n_fc         = NUMBER_BYTES;
                            w_step_phase = PH_NUM;
                        end else if (i_data_byte == TY_BOOL) begin
                            w_step_phase = PH_BOOL;
                        end else if (i_data_byte == TY_STRING) begin
                            w_step_phase = PH_SLEN_HI;
                        end else begin
                            w_step_phase = PH_IDLE;
                        end
                    end
                    PH_NUM: begin
                        n_fc = w_fc_dec;
                        if (w_fc_dec == 16'd0) w_step_phase = PH_KLEN_HI;
                    end
                    PH_BOOL: begin
                        w_step_phase = PH_KLEN_HI;
                    end
                    PH_SLEN_HI: begin
                        n_pl         = {i_data_byte, 8'h00};
                        w_step_phase = PH_SLEN_LO;
                    end
                    PH_SLEN_LO: begin
                        n_pl = w_len_lo;
                        if (w_len_lo != 16'd0) begin
                            n_fc         = w_len_lo;
                            w_step_phase = PH_STR;
                        end else begin
                            w_step_phase = PH_KLEN_HI_S;
                        end
                    end
                    PH_STR: begin
                        n_fc = w_fc_dec;
                        if (w_fc_dec == 16'd0) w_step_phase = PH_KLEN_HI_S;
                    end
                    default: begin
                        w_step_phase = PH_IDLE;
                    end
                endcase
            end
        end
        // last byte that leaves the decode open ends it
        n_phase = w_step_phase;
        if (i_acc && i_buffer_end && w_step_phase != PH_IDLE) n_phase = PH_IDLE;
    end

    // classified operation
    always_comb begin
        o_op = '0;
        if (i_acc) begin
            if (i_first_byte) begin
                if (w_step_phase == PH_IDLE) begin
                    o_op.emit = 1'b1;
                    o_op.kind = EV_ERROR;
                    o_op.err  = ERR_BAD_TOP;
                    o_op.fin  = 1'b1;
                end
            end else if (r_phase != PH_IDLE) begin
                case (r_phase)
                    PH_KLEN_HI_S: begin
                        o_op.emit = 1'b1;
                        o_op.kind = EV_STR_DONE;
                        o_op.len  = {16'd0, r_pl};
                    end
                    PH_KEY: begin
                        o_op.emit = 1'b1;
                        o_op.kind = EV_KEY_BYTE;
                        o_op.data = i_data_byte;
                    end
                    PH_TYPE: begin
                        o_op.emit = 1'b1;
                        if (r_pl == 16'd0 && i_data_byte == MK_OBJ_END) begin
                            o_op.kind = EV_END;
                            o_op.len  = n_ct;
                            o_op.fin  = 1'b1;
                        end else if (i_data_byte inside {[TY_NUMBER:TY_STRING]}) begin
                            o_op.kind = EV_KEY_DONE;
                            o_op.len  = {16'd0, r_pl};
                        end else begin
                            o_op.kind = EV_ERROR;
                            o_op.err  = ERR_BAD_TYPE;
                            o_op.fin  = 1'b1;
                        end
                    end
                    PH_NUM: begin
                        o_op.data = i_data_byte;
                        if (w_fc_dec == 16'd0) begin
                            o_op.emit = 1'b1;
                            o_op.kind = EV_NUMBER;
                        end else begin
                            o_op.shift = 1'b1;
                        end
                    end
                    PH_BOOL: begin
                        o_op.emit = 1'b1;
                        o_op.kind = EV_BOOL;
                        o_op.data = i_data_byte;
                    end
                    PH_STR: begin
                        o_op.emit = 1'b1;
                        o_op.kind = EV_STR_BYTE;
                        o_op.data = i_data_byte;
                    end
                    default: begin
                        o_op = '0;
                    end
                endcase
            end
            if (i_buffer_end && w_step_phase != PH_IDLE) begin
                o_op      = '0;
                o_op.emit = 1'b1;
                o_op.kind = EV_ERROR;
                o_op.err  = ERR_TRUNCATED;
                o_op.fin  = 1'b1;
            end
        end
        o_op_valid = o_op.emit | o_op.shift;
    end

endmodule

FILE: rtl/amf0osd_queue.sv
module amf0osd_queue
    import amf0osd_pkg::*;
#(
    parameter int DEPTH = 4
) (
    input  logic i_clk,
    input  logic i_rst_n,
    input  logic i_wr,
    input  t_op  i_wr_op,
    output logic o_full,
    input  logic i_rd,
    output logic o_valid,
    output t_op  o_rd_op
);

    localparam int PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CW = $clog2(DEPTH + 1);
    localparam logic [PW-1:0] LAST_PTR = PW'(DEPTH - 1);
    localparam logic [CW-1:0] FULL_CNT = CW'(DEPTH);

    t_op           r_mem [DEPTH];
    logic [PW-1:0] r_wp, r_rp;
    logic [CW-1:0] r_count;
    logic          w_do_wr, w_do_rd;

    assign o_full  = (r_count == FULL_CNT);
    assign o_valid = (r_count != '0);
    assign o_rd_op = r_mem[r_rp];
    assign w_do_wr = i_wr && !o_full;
    assign w_do_rd = i_rd && o_valid;

    always_ff @(posedge i_clk) begin
        if (w_do_wr) r_mem[r_wp] <= i_wr_op;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wp    <= '0;
            r_rp    <= '0;
            r_count <= '0;
        end else begin
            if (w_do_wr) r_wp <= (r_wp == LAST_PTR) ? '0 : r_wp + PW'(1);
            if (w_do_rd) r_rp <= (r_rp == LAST_PTR) ? '0 : r_rp + PW'(1);
            case ({w_do_wr, w_do_rd})
                2'b10:   r_count <= r_count + CW'(1);
                2'b01:   r_count <= r_count - CW'(1);
                default: r_count <= r_count;
            endcase
        end
    end

endmodule

FILE: rtl/amf0osd_back.sv
module amf0osd_back
    import amf0osd_pkg::*;
(
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_op_valid,
    input  t_op         i_op,
    output logic        o_op_take,
    output logic        o_valid,
    input  logic        i_pop,
    output logic [2:0]  o_event_kind,
    output logic [7:0]  o_byte_value,
    output logic [63:0] o_number_bits,
    output logic        o_bool_value,
    output logic [31:0] o_length_value,
    output logic [1:0]  o_error_code,
    output logic        o_final_result
);

    logic        r_valid;
    logic [55:0] r_shift;
    logic [2:0]  r_kind;
    logic [7:0]  r_byte;
    logic [63:0] r_num;
    logic        r_bool;
    logic [31:0] r_len;
    logic [1:0]  r_err;
    logic        r_fin;
    logic        w_load;

    // shift-only ops never wait on the result word
    assign o_op_take = i_op_valid && (i_op.shift || !r_valid || i_pop);
    assign w_load    = o_op_take && i_op.emit;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (w_load) begin
            r_valid <= 1'b1;
        end else if (i_pop) begin
            r_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_op_take && i_op.shift) r_shift <= {r_shift[47:0], i_op.data};
        if (w_load) begin
            r_kind <= i_op.kind;
            r_byte <= (i_op.kind inside {EV_KEY_BYTE, EV_STR_BYTE}) ? i_op.data : 8'h00;
            r_num  <= (i_op.kind == EV_NUMBER) ? {r_shift, i_op.data} : 64'd0;
            r_bool <= (i_op.kind == EV_BOOL) && (i_op.data == BOOL_TRUE);
            r_len  <= i_op.len;
            r_err  <= i_op.err;
            r_fin  <= i_op.fin;
        end
    end

    assign o_valid        = r_valid;
    assign o_event_kind   = r_kind;
    assign o_byte_value   = r_byte;
    assign o_number_bits  = r_num;
    assign o_bool_value   = r_bool;
    assign o_length_value = r_len;
    assign o_error_code   = r_err;
    assign o_final_result = r_fin;

endmodule

FILE: rtl/amf0_object_stream_decoder_unit.sv
// amf0 object / ecma array decoder, one buffer byte per word
//
// input queue side: drive data, first_byte (top marker, restarts the decode)
// and buffer_end (last valid byte) with push; a word is taken when push is
// high and full is low. result queue side: while empty is low the oldest
// event sits on the o_ ports; it is taken when pop is high.
// events: key byte, key done, number (64-bit pattern), boolean, string byte,
// string done, object end with byte total, error (final_result set)
//
// throughput: one byte per cycle while full is low; the parser step is combinational
// path: an accepted byte's event goes from the parser into the op queue,
// then into the result register, before it reaches the ports
// the result stage shifts in non-final number bytes, which never wait on pop
// stall: while pop is low the op queue fills and full rises once
// QUEUE_DEPTH ops are held; the parser keeps its phase meanwhile
// reset (synchronous, active low): parser idle, queue and result emptied;
// bytes without first_byte before a top marker are dropped
`include "amf0_object_stream_decoder_unit_defines.svh"

module amf0_object_stream_decoder_unit
    import amf0osd_pkg::*;
#(
    parameter int QUEUE_DEPTH = 4
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        push,
    output logic        full,
    input  logic [7:0]  i_data_byte,
    input  logic        i_first_byte,
    input  logic        i_buffer_end,
    output logic        empty,
    input  logic        pop,
    output logic [2:0]  o_event_kind,
    output logic [7:0]  o_byte_value,
    output logic [63:0] o_number_bits,
    output logic        o_bool_value,
    output logic [31:0] o_length_value,
    output logic [1:0]  o_error_code,
    output logic        o_final_result
);

    logic w_acc;       // input word taken
    logic w_op_valid;  // parser produced an op
    t_op  w_op;
    logic w_q_valid;   // op queue head present
    t_op  w_q_op;
    logic w_q_take;
    logic w_out_valid;
    logic w_pop_acc;

    assign w_acc     = push && !full;
    assign w_pop_acc = pop && !empty;

    // front: phase tracking and classification
    amf0osd_front u_front (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_acc        (w_acc),
        .i_data_byte  (i_data_byte),
        .i_first_byte (i_first_byte),
        .i_buffer_end (i_buffer_end),
        .o_op_valid   (w_op_valid),
        .o_op         (w_op)
    );

    // op queue decoupling parser from result stage
    amf0osd_queue #(
        .DEPTH (QUEUE_DEPTH)
    ) u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_wr    (w_op_valid),
        .i_wr_op (w_op),
        .o_full  (full),
        .i_rd    (w_q_take),
        .o_valid (w_q_valid),
        .o_rd_op (w_q_op)
    );

    // back: number assembly and result formatting
    amf0osd_back u_back (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_op_valid     (w_q_valid),
        .i_op           (w_q_op),
        .o_op_take      (w_q_take),
        .o_valid        (w_out_valid),
        .i_pop          (w_pop_acc),
        .o_event_kind   (o_event_kind),
        .o_byte_value   (o_byte_value),
        .o_number_bits  (o_number_bits),
        .o_bool_value   (o_bool_value),
        .o_length_value (o_length_value),
        .o_error_code   (o_error_code),
        .o_final_result (o_final_result)
    );

    assign empty = !w_out_valid;

    // final results are only ends and errors
    `AMF0_ASSERT_IMPLY(a_fin_kind, i_clk, i_rst_n, !empty && o_final_result,
        o_event_kind == EV_END || o_event_kind == EV_ERROR)
    // an error word always carries a cause
    `AMF0_ASSERT_IMPLY(a_err_code, i_clk, i_rst_n, !empty && o_event_kind == EV_ERROR,
        o_error_code != ERR_NONE)
    // boolean flag only on boolean events
    `AMF0_ASSERT_IMPLY(a_bool_kind, i_clk, i_rst_n, !empty && o_bool_value,
        o_event_kind == EV_BOOL)
    // popped result with nothing queued leaves the output empty
    `AMF0_ASSERT_NEXT(a_drain, i_clk, i_rst_n, w_pop_acc && !w_q_valid, empty)

endmodule

FILE: tb/amf0_object_stream_decoder_unit_checker.sv
// watches both queue sides of the decoder, predicts events per accepted word
// and compares each popped event with the oldest prediction
module amf0_decode_checker
    import amf0osd_pkg::*;
(
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_push,
    input  logic        i_full,
    input  logic [7:0]  i_data_byte,
    input  logic        i_first_byte,
    input  logic        i_buffer_end,
    input  logic        i_empty,
    input  logic        i_pop,
    input  logic [2:0]  i_event_kind,
    input  logic [7:0]  i_byte_value,
    input  logic [63:0] i_number_bits,
    input  logic        i_bool_value,
    input  logic [31:0] i_length_value,
    input  logic [1:0]  i_error_code,
    input  logic        i_final_result,
    output int          o_fail_count,
    output int          o_pending,
    output int          o_checked
);
    timeunit 1ns;
    timeprecision 1ps;

    typedef struct packed {
        logic [2:0]  kind;
        logic [7:0]  byte_val;
        logic [63:0] num;
        logic        bool_val;
        logic [31:0] len;
        logic [1:0]  err;
        logic        fin;
    } t_event;

    // decoder state as predicted
    t_phase      phase;
    logic [15:0] fld_cnt;
    logic [15:0] pend_len;
    logic [63:0] num_acc;
    logic [31:0] total;

    t_event pending_events[$];
    int     fail_cnt;
    int     checked_cnt;

    assign o_fail_count = fail_cnt;
    assign o_checked    = checked_cnt;

    function automatic t_event make_event(input logic [2:0] kind, input logic [7:0] b,
                                          input logic [63:0] num, input logic bv,
                                          input logic [31:0] len, input logic [1:0] err,
                                          input logic fin);
        t_event ev;
        ev.kind     = kind;
        ev.byte_val = b;
        ev.num      = num;
        ev.bool_val = bv;
        ev.len      = len;
        ev.err      = err;
        ev.fin      = fin;
        return ev;
    endfunction

    // one buffer byte through the parser; returns 1 when it yields an event
    function automatic bit decode_byte(input logic [7:0] d, input logic first,
                                       input logic last, output t_event ev);
        bit hit;
        hit = 1'b0;
        ev  = '0;
        if (first) begin
            fld_cnt  = '0;
            pend_len = '0;
            num_acc  = '0;
            total    = 32'd1;
            if (d == MK_OBJECT) begin
                phase = PH_KLEN_HI;
            end else if (d == MK_ECMA) begin
                phase   = PH_COUNT;
                fld_cnt = ECMA_COUNT_BYTES;
            end else begin
                phase = PH_IDLE;
                ev = make_event(EV_ERROR, 8'h00, '0, 1'b0, '0, ERR_BAD_TOP, 1'b1);
                return 1'b1;
            end
            if (last) begin
                phase = PH_IDLE;
                ev = make_event(EV_ERROR, 8'h00, '0, 1'b0, '0, ERR_TRUNCATED, 1'b1);
                hit = 1'b1;
            end
            return hit;
        end

        if (phase == PH_IDLE)
            return 1'b0;

        if (total != 32'hFFFF_FFFF)
            total = total + 32'd1;

        case (phase)
            PH_COUNT: begin
                fld_cnt = fld_cnt - 16'd1;
                if (fld_cnt == 16'd0)
                    phase = PH_KLEN_HI;
            end
            PH_KLEN_HI_S: begin
                ev = make_event(EV_STR_DONE, 8'h00, '0, 1'b0, {16'h0, pend_len}, ERR_NONE, 1'b0);
                hit      = 1'b1;
                pend_len = {d, 8'h00};
                phase    = PH_KLEN_LO;
            end
            PH_KLEN_HI: begin
                pend_len = {d, 8'h00};
                phase    = PH_KLEN_LO;
            end
            PH_KLEN_LO: begin
                pend_len = pend_len | {8'h00, d};
                if (pend_len != 16'd0) begin
                    fld_cnt = pend_len;
                    phase   = PH_KEY;
                end else begin
                    phase = PH_TYPE;
                end
            end
            PH_KEY: begin
                ev = make_event(EV_KEY_BYTE, d, '0, 1'b0, '0, ERR_NONE, 1'b0);
                hit     = 1'b1;
                fld_cnt = fld_cnt - 16'd1;
                if (fld_cnt == 16'd0)
                    phase = PH_TYPE;
            end
            PH_TYPE: begin
                hit = 1'b1;
                if (pend_len == 16'd0 && d == MK_OBJ_END) begin
                    ev = make_event(EV_END, 8'h00, '0, 1'b0, total, ERR_NONE, 1'b1);
                    phase = PH_IDLE;
                end else if (d <= TY_STRING) begin
                    ev = make_event(EV_KEY_DONE, 8'h00, '0, 1'b0, {16'h0, pend_len},
                                    ERR_NONE, 1'b0);
                    if (d == TY_NUMBER) begin
                        fld_cnt = NUMBER_BYTES;
                        num_acc = '0;
                        phase   = PH_NUM;
                    end else if (d == TY_BOOL) begin
                        phase = PH_BOOL;
                    end else begin
                        phase = PH_SLEN_HI;
                    end
                end else begin
                    ev = make_event(EV_ERROR, 8'h00, '0, 1'b0, '0, ERR_BAD_TYPE, 1'b1);
                    phase = PH_IDLE;
                end
            end
            PH_NUM: begin
                num_acc = {num_acc[55:0], d};
                fld_cnt = fld_cnt - 16'd1;
                if (fld_cnt == 16'd0) begin
                    ev = make_event(EV_NUMBER, 8'h00, num_acc, 1'b0, '0, ERR_NONE, 1'b0);
                    hit   = 1'b1;
                    phase = PH_KLEN_HI;
                end
            end
            PH_BOOL: begin
                ev = make_event(EV_BOOL, 8'h00, '0, d == BOOL_TRUE, '0, ERR_NONE, 1'b0);
                hit   = 1'b1;
                phase = PH_KLEN_HI;
            end
            PH_SLEN_HI: begin
                pend_len = {d, 8'h00};
                phase    = PH_SLEN_LO;
            end
            PH_SLEN_LO: begin
                pend_len = pend_len | {8'h00, d};
                if (pend_len != 16'd0) begin
                    fld_cnt = pend_len;
                    phase   = PH_STR;
                end else begin
                    phase = PH_KLEN_HI_S;
                end
            end
            PH_STR: begin
                ev = make_event(EV_STR_BYTE, d, '0, 1'b0, '0, ERR_NONE, 1'b0);
                hit     = 1'b1;
                fld_cnt = fld_cnt - 16'd1;
                if (fld_cnt == 16'd0)
                    phase = PH_KLEN_HI_S;
            end
            default: begin
                phase = PH_IDLE;
                return 1'b0;
            end
        endcase

        if (last && phase != PH_IDLE) begin
            phase = PH_IDLE;
            ev = make_event(EV_ERROR, 8'h00, '0, 1'b0, '0, ERR_TRUNCATED, 1'b1);
            hit = 1'b1;
        end
        return hit;
    endfunction

    always @(posedge i_clk) begin : watch
        t_event pred_ev;
        t_event exp_ev;
        t_event got_ev;
        bit     hit;
        if (!i_rst_n) begin
            phase    = PH_IDLE;
            fld_cnt  = '0;
            pend_len = '0;
            num_acc  = '0;
            total    = '0;
            pending_events.delete();
        end else begin
            if (i_push && !i_full) begin
                hit = decode_byte(i_data_byte, i_first_byte, i_buffer_end, pred_ev);
                if (hit)
                    pending_events.push_back(pred_ev);
            end
            if (i_pop && !i_empty) begin
                got_ev = {i_event_kind, i_byte_value, i_number_bits, i_bool_value,
                          i_length_value, i_error_code, i_final_result};
                if (pending_events.size() == 0) begin
                    fail_cnt = fail_cnt + 1;
                    if (fail_cnt <= 10)
                        $display("%0t: event kind=%0d popped with nothing predicted",
                                 $realtime, i_event_kind);
                end else begin
                    exp_ev = pending_events.pop_front();
                    checked_cnt = checked_cnt + 1;
                    if (got_ev !== exp_ev) begin
                        fail_cnt = fail_cnt + 1;
                        if (fail_cnt <= 10) begin
                            $display("%0t: event differs", $realtime);
                            $display("  exp kind=%0d byte=%h num=%h bool=%b len=%0d err=%0d fin=%b",
                                     exp_ev.kind, exp_ev.byte_val, exp_ev.num,
                                     exp_ev.bool_val, exp_ev.len, exp_ev.err, exp_ev.fin);
                            $display("  got kind=%0d byte=%h num=%h bool=%b len=%0d err=%0d fin=%b",
                                     got_ev.kind, got_ev.byte_val, got_ev.num,
                                     got_ev.bool_val, got_ev.len, got_ev.err, got_ev.fin);
                        end
                    end
                end
            end
        end
        o_pending = pending_events.size();
    end

endmodule

FILE: tb/tb.sv
// top of the decoder bench: drives amf0 byte frames into the input queue,
// pops events at random, and gives the verdict from the checker's counts
module tb
    import amf0osd_pkg::*;
();
    timeunit 1ns;
    timeprecision 1ps;

    localparam int STREAM_BYTES = 1100;   // stop offering frames past this
    localparam int QUIET_FROM   = 950;    // no idling on either side after this
    localparam int HOLD_AT      = 900;    // cycle of the long pop hold-off
    localparam int HOLD_LEN     = 400;
    localparam int DRAIN_CYCLES = 20;     // covers the op queue and result register, taken with margin

    logic        i_clk;
    logic        i_rst_n;
    logic        push;
    logic        full;
    logic [7:0]  i_data_byte;
    logic        i_first_byte;
    logic        i_buffer_end;
    logic        empty;
    logic        pop;
    logic [2:0]  o_event_kind;
    logic [7:0]  o_byte_value;
    logic [63:0] o_number_bits;
    logic        o_bool_value;
    logic [31:0] o_length_value;
    logic [1:0]  o_error_code;
    logic        o_final_result;

    int fail_count;
    int pending;
    int checked;

    // stimulus bookkeeping
    int         bytes_sent;
    int         frames_sent;
    bit         quiet;
    logic [7:0] frame_q[$];

    amf0_object_stream_decoder_unit dut (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .push           (push),
        .full           (full),
        .i_data_byte    (i_data_byte),
        .i_first_byte   (i_first_byte),
        .i_buffer_end   (i_buffer_end),
        .empty          (empty),
        .pop            (pop),
        .o_event_kind   (o_event_kind),
        .o_byte_value   (o_byte_value),
        .o_number_bits  (o_number_bits),
        .o_bool_value   (o_bool_value),
        .o_length_value (o_length_value),
        .o_error_code   (o_error_code),
        .o_final_result (o_final_result)
    );

    amf0_decode_checker u_checker (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_push         (push),
        .i_full         (full),
        .i_data_byte    (i_data_byte),
        .i_first_byte   (i_first_byte),
        .i_buffer_end   (i_buffer_end),
        .i_empty        (empty),
        .i_pop          (pop),
        .i_event_kind   (o_event_kind),
        .i_byte_value   (o_byte_value),
        .i_number_bits  (o_number_bits),
        .i_bool_value   (o_bool_value),
        .i_length_value (o_length_value),
        .i_error_code   (o_error_code),
        .i_final_result (o_final_result),
        .o_fail_count   (fail_count),
        .o_pending      (pending),
        .o_checked      (checked)
    );

    // 10 ns clock
    initial i_clk = 1'b0;
    always begin
        #5 i_clk = 1'b1;
        #5 i_clk = 1'b0;
    end

    // offer one word and hold it until the input queue takes it;
    // returns in the time step of the accepting edge
    task automatic send_word(input logic [7:0] d, input logic f, input logic l);
        int gap;
        if (!quiet && $urandom_range(0, 4) == 0) begin
            gap = $urandom_range(1, 11);
            push <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        push         <= 1'b1;
        i_data_byte  <= d;
        i_first_byte <= f;
        i_buffer_end <= l;
        @(posedge i_clk);
        while (full) @(posedge i_clk);
    endtask

    // send frame_q[0..stop_idx], top marker flag on the first byte,
    // buffer end on the last one sent when end_flag is set
    task automatic send_frame(input int stop_idx, input bit end_flag);
        for (int i = 0; i <= stop_idx; i++)
            send_word(frame_q[i], i == 0, end_flag && i == stop_idx);
        frames_sent = frames_sent + 1;
        bytes_sent  = bytes_sent + stop_idx + 1;
    endtask

    // object or ecma array with random entries and content, some with a bad value type
    task automatic build_frame();
        int         n_entries;
        int         klen;
        int         slen;
        int         sel;
        logic [7:0] ty;
        frame_q.delete();
        if ($urandom_range(0, 2) == 0) begin
            frame_q.push_back(MK_ECMA);
            repeat (4) frame_q.push_back(8'($urandom));   // element count, skipped
        end else begin
            frame_q.push_back(MK_OBJECT);
        end
        n_entries = $urandom_range(0, 5);
        repeat (n_entries) begin
            // mostly short keys, now and then a long one
            klen = ($urandom_range(0, 99) == 0) ? $urandom_range(200, 300)
                                                : $urandom_range(0, 6);
            frame_q.push_back(klen[15:8]);
            frame_q.push_back(klen[7:0]);
            repeat (klen) frame_q.push_back(8'($urandom));
            sel = $urandom_range(0, 19);
            if (sel < 6) begin
                frame_q.push_back(TY_NUMBER);
                repeat (8) frame_q.push_back(8'($urandom));
            end else if (sel < 12) begin
                frame_q.push_back(TY_BOOL);
                if ($urandom_range(0, 2) == 0)
                    frame_q.push_back(8'($urandom));
                else
                    frame_q.push_back(8'($urandom_range(0, 1)));
            end else if (sel < 19) begin
                frame_q.push_back(TY_STRING);
                slen = ($urandom_range(0, 49) == 0) ? $urandom_range(200, 260)
                                                    : $urandom_range(0, 8);
                frame_q.push_back(slen[15:8]);
                frame_q.push_back(slen[7:0]);
                repeat (slen) frame_q.push_back(8'($urandom));
            end else begin
                // unsupported value type
                ty = 8'($urandom_range(3, 255));
                frame_q.push_back(ty);
            end
        end
        frame_q.push_back(8'h00);
        frame_q.push_back(8'h00);
        frame_q.push_back(MK_OBJ_END);
    endtask

    // result side: random pop bursts, one long hold-off, none at the end
    initial begin : pop_side
        int cyc;
        int gap;
        bit held;
        cyc  = 0;
        held = 1'b0;
        pop <= 1'b0;
        @(posedge i_clk);
        while (!i_rst_n) @(posedge i_clk);
        forever begin
            @(posedge i_clk);
            cyc = cyc + 1;
            if (!held && cyc >= HOLD_AT) begin
                // long stall: input queue fills while the sender keeps offering
                held = 1'b1;
                pop <= 1'b0;
                repeat (HOLD_LEN - 1) @(posedge i_clk);
                cyc = cyc + HOLD_LEN - 1;
            end else if (!quiet && $urandom_range(0, 5) == 0) begin
                gap = $urandom_range(1, 11);
                pop <= 1'b0;
                repeat (gap - 1) @(posedge i_clk);
                cyc = cyc + gap - 1;
            end else begin
                pop <= 1'b1;
            end
        end
    end

    // stimulus and verdict
    initial begin : stimulus
        int r;
        int cut;
        int idx;
        int n;
        push         <= 1'b0;
        i_data_byte  <= 8'h00;
        i_first_byte <= 1'b0;
        i_buffer_end <= 1'b0;
        i_rst_n      <= 1'b0;
        quiet        = 1'b0;
        bytes_sent   = 0;
        frames_sent  = 0;
        repeat (5) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // directed: bad top marker
        frame_q = '{8'hFF};
        send_frame(0, 1'b0);
        // buffer end on the top marker itself
        frame_q = '{MK_ECMA};
        send_frame(0, 1'b1);
        // key byte, true boolean, empty key with one-byte string, end marker
        frame_q = '{MK_OBJECT, 8'h00, 8'h01, 8'hFF, TY_BOOL, BOOL_TRUE,
                    8'h00, 8'h00, TY_STRING, 8'h00, 8'h01, 8'h00,
                    8'h00, 8'h00, MK_OBJ_END};
        send_frame(14, 1'b1);
        // unsupported value type after an empty key
        frame_q = '{MK_OBJECT, 8'h00, 8'h00, 8'h05};
        send_frame(3, 1'b0);
        // dropped while idle
        send_word(8'hA5, 1'b0, 1'b0);

        // random frames: mostly well formed, the rest cut, restarted or damaged
        while (bytes_sent < STREAM_BYTES) begin
            if (bytes_sent >= QUIET_FROM)
                quiet = 1'b1;
            build_frame();
            r = $urandom_range(0, 99);
            if (r < 60) begin
                send_frame(frame_q.size() - 1, $urandom_range(0, 3) != 0);
            end else if (r < 72) begin
                // truncated somewhere inside
                cut = $urandom_range(0, frame_q.size() - 1);
                send_frame(cut, 1'b1);
            end else if (r < 78) begin
                // cut short, the next frame restarts the decode
                cut = $urandom_range(0, frame_q.size() - 1);
                send_frame(cut, 1'b0);
            end else if (r < 88) begin
                idx = $urandom_range(0, frame_q.size() - 1);
                frame_q[idx] = 8'($urandom);
                send_frame(frame_q.size() - 1, 1'b1);
            end else if (r < 95) begin
                // loose bytes, sometimes flagged as top marker or buffer end
                n = $urandom_range(1, 5);
                repeat (n)
                    send_word(8'($urandom), $urandom_range(0, 3) == 0,
                              1'($urandom_range(0, 1)));
            end else begin
                // maximum key or string length, truncated after a few bytes
                if ($urandom_range(0, 1) == 0)
                    frame_q = '{MK_OBJECT, 8'hFF, 8'hFF};
                else
                    frame_q = '{MK_OBJECT, 8'h00, 8'h00, TY_STRING, 8'hFF, 8'hFF};
                n = $urandom_range(1, 6);
                repeat (n) frame_q.push_back(8'($urandom));
                send_frame(frame_q.size() - 1, 1'b1);
            end
        end
        push <= 1'b0;

        @(posedge i_clk);
        while (pending != 0) @(posedge i_clk);
        repeat (DRAIN_CYCLES) @(posedge i_clk);

        $display("covered %0d frames, %0d bytes accepted, %0d events compared",
                 frames_sent, bytes_sent, checked);
        $display("objects, ecma arrays, cut and damaged frames, one %0d-cycle pop stall",
                 HOLD_LEN);
        if (fail_count == 0 && pending == 0) begin
            $display("amf0_object_stream_decoder_unit: match");
        end else begin
            $display("amf0_object_stream_decoder_unit: mismatch");
        end
        $finish;
    end

    // watchdog
    initial begin
        #3000000;
        $display("amf0_object_stream_decoder_unit: mismatch");
        $finish;
    end

endmodule
